// File: hw/rtl/png_idat_chunk_extractor_macros.svh
// Assertion macros for the IDAT extractor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PNG_IDAT_CHUNK_EXTRACTOR_MACROS_SVH
`define PNG_IDAT_CHUNK_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define IDATX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IDATX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/idatx_pkg.sv
// Types and constants for the PNG IDAT chunk extractor.
// Depends on nothing; used by every module of the block.
`default_nettype none

package idatx_pkg;

   // Chunk type codes, big-endian ASCII.
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

   // Index of the last of the four CRC bytes after each chunk payload.
   localparam logic [2:0] CRC_LAST_INDEX = 3'd3;

   // Parser phase, one-hot.
   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_CRC     = 3'b100
   } phase_type;

   // One input item: a file byte and its end-of-file flag.
   typedef struct packed {
      logic [7:0] stream_byte;
      logic       final_byte;
   } item_type;

   // One result item.
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       end_of_data;
   } rslt_type;

endpackage

`default_nettype wire

// File: hw/rtl/png_idat_chunk_extractor.sv
// PNG IDAT chunk extractor: one file byte in, at most one IDAT payload byte out.
// An accepted item is held in the input register, then passes through the parser into the
// result register, from which its result is taken.
// Throughput: one item per cycle while rsp_stall is low; the parser is combinational.
// Reset (synchronous, active high) empties both registers and returns the parser to the
// header phase. Depends on idatx_pkg, idatx_in_reg, idatx_parser and idatx_out_reg.
`default_nettype none

module png_idat_chunk_extractor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_stream_byte,
   input  wire logic       req_final_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_has_byte,
   output logic            rsp_end_of_data
);

   idatx_pkg::item_type req_item;
   idatx_pkg::item_type item;
   idatx_pkg::rslt_type rslt;
   idatx_pkg::rslt_type rsp_rslt;
   logic                item_valid;
   logic                rslt_valid;
   logic                out_free;

   assign req_item.stream_byte = req_stream_byte;
   assign req_item.final_byte  = req_final_byte;

   idatx_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .out_free   (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   idatx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .rslt_valid (rslt_valid),
      .rslt       (rslt)
   );

   idatx_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .rslt_valid (rslt_valid),
      .rslt       (rslt),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_rslt   (rsp_rslt)
   );

   assign rsp_payload_byte = rsp_rslt.payload_byte;
   assign rsp_has_byte     = rsp_rslt.has_byte;
   assign rsp_end_of_data  = rsp_rslt.end_of_data;

endmodule

`default_nettype wire

// File: hw/rtl/idatx_in_reg.sv
// Input register of the IDAT extractor: holds one accepted item for the parser.
// Depends on idatx_pkg.
`default_nettype none

module idatx_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire idatx_pkg::item_type req_item,
   input  wire logic               out_free,
   output logic                    item_valid,
   output idatx_pkg::item_type     item
);

   logic                in_valid_ff;
   logic                in_valid_in;
   idatx_pkg::item_type item_ff;
   logic                accept;
   logic                consume;

   // The held item moves on whenever the result register can take a result.
   assign consume   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = consume;
   assign item       = item_ff;

endmodule

`default_nettype wire

// File: hw/rtl/idatx_parser.sv
// Chunk parser of the IDAT extractor: header gathering, payload count and CRC skip.
// Depends on idatx_pkg and png_idat_chunk_extractor_macros.svh.
`default_nettype none
`include "png_idat_chunk_extractor_macros.svh"

module idatx_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire idatx_pkg::item_type item,
   output logic                     rslt_valid,
   output idatx_pkg::rslt_type      rslt
);

   idatx_pkg::phase_type phase_ff, phase_in;
   logic [55:0]          hdr_ff, hdr_in;
   logic [2:0]           idx_ff, idx_in;
   logic [31:0]          left_ff, left_in;
   logic                 in_idat_ff, in_idat_in;
   logic                 finished_ff, finished_in;
   logic [63:0]          full_hdr;
   logic [31:0]          chunk_len;
   logic [31:0]          chunk_type;
   logic                 has;
   logic                 ends;
   logic [7:0]           data;

   // The eighth header byte completes the length and type words.
   assign full_hdr   = {hdr_ff, item.stream_byte};
   assign chunk_len  = full_hdr[63:32];
   assign chunk_type = full_hdr[31:0];

   // Next-state and result logic for one item.
   always_comb begin
      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      idx_in      = idx_ff;
      left_in     = left_ff;
      in_idat_in  = in_idat_ff;
      finished_in = finished_ff;
      has         = 1'b0;
      ends        = 1'b0;
      data        = 8'd0;
      if (item_valid && !finished_ff) begin
         case (phase_ff)
            idatx_pkg::PH_PAYLOAD: begin
               has     = in_idat_ff;
               data    = in_idat_ff ? item.stream_byte : 8'd0;
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  phase_in = idatx_pkg::PH_CRC;
                  idx_in   = 3'd0;
               end
            end
            idatx_pkg::PH_CRC: begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == idatx_pkg::CRC_LAST_INDEX) begin
                  phase_in = idatx_pkg::PH_HEADER;
                  idx_in   = 3'd0;
               end
            end
            default: begin
               // Header phase; an unknown code is handled the same way.
               phase_in = idatx_pkg::PH_HEADER;
               hdr_in   = {hdr_ff[47:0], item.stream_byte};
               idx_in   = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  if (chunk_type == idatx_pkg::TYPE_IEND) begin
                     ends = 1'b1;
                  end else begin
                     in_idat_in = (chunk_type == idatx_pkg::TYPE_IDAT);
                     left_in    = chunk_len;
                     phase_in   = (chunk_len == 32'd0) ? idatx_pkg::PH_CRC
                                                       : idatx_pkg::PH_PAYLOAD;
                  end
               end
            end
         endcase
         if (item.final_byte) begin
            ends = 1'b1;
         end
         if (ends) begin
            finished_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= idatx_pkg::PH_HEADER;
         idx_ff      <= 3'd0;
         left_ff     <= 32'd0;
         in_idat_ff  <= 1'b0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         left_ff     <= left_in;
         in_idat_ff  <= in_idat_in;
         finished_ff <= finished_in;
      end
   end

   // Header bytes are always refilled before they are decoded.
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   assign rslt_valid        = has || ends;
   assign rslt.payload_byte = data;
   assign rslt.has_byte     = has;
   assign rslt.end_of_data  = ends;

   `IDATX_ASSERT_NEXT(a_finished_sticks, clock, reset, finished_ff, finished_ff,
      "parser left the finished state")
   `IDATX_ASSERT_NOW(a_byte_only_in_idat, clock, reset, rslt_valid && rslt.has_byte,
      (phase_ff == idatx_pkg::PH_PAYLOAD) && in_idat_ff, "data byte outside IDAT payload")
   `IDATX_ASSERT_NOW(a_payload_count, clock, reset, phase_ff == idatx_pkg::PH_PAYLOAD,
      left_ff != 32'd0, "payload phase with no bytes left")
   `IDATX_ASSERT_NOW(a_crc_index, clock, reset, phase_ff == idatx_pkg::PH_CRC,
      idx_ff <= idatx_pkg::CRC_LAST_INDEX, "CRC byte index out of range")

endmodule

`default_nettype wire

// File: hw/rtl/idatx_out_reg.sv
// Result register of the IDAT extractor: holds one result item until it is taken.
// Depends on idatx_pkg.
`default_nettype none

module idatx_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rslt_valid,
   input  wire idatx_pkg::rslt_type rslt,
   output logic                     out_free,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output idatx_pkg::rslt_type      rsp_rslt
);

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   idatx_pkg::rslt_type rslt_ff;

   // Room for a new result when empty or when the held one leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (rslt_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rslt_valid) begin
         rslt_ff <= rslt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rslt  = rslt_ff;

endmodule

`default_nettype wire
